>>> rtl/core/lss_pkg.sv
// Shared types and constants for the log slot scanner.
// No dependencies; used by lss_update and log_slot_scanner_top.
package lss_pkg;

  localparam int SLOTS_PER_PAGE = 4;

  localparam int PAGE_W  = 5;
  localparam int SLOT_W  = 2;
  localparam int END_W   = 6;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 7;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int STAMP_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W;
  localparam int CFG_W   = 6;
  localparam int CIDX_W  = 2;

  // Register indexes of the configuration port
  localparam logic [CIDX_W-1:0] CFG_FIRST_PAGE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_END_PAGE   = 2'd1;

  localparam logic [PAGE_W-1:0] FIRST_PAGE_RST = 5'd2;
  localparam logic [END_W-1:0]  END_PAGE_RST   = 6'd17;

  // Oldest search starts from 60-12-31 23:59
  localparam logic [STAMP_W-1:0] SENTINEL_STAMP =
    {7'd60, 4'd12, 5'd31, 5'd23, 6'd59};

  localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(SLOTS_PER_PAGE - 1);

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [SLOT_W-1:0]  slot;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic               first;
    logic               last;
  } entry_t;

  typedef struct packed {
    logic [STAMP_W-1:0] oldest_stamp;
    logic [PAGE_W-1:0]  oldest_page;
    logic [SLOT_W-1:0]  oldest_slot;
    logic [STAMP_W-1:0] latest_stamp;
    logic [PAGE_W-1:0]  latest_page;
    logic [SLOT_W-1:0]  latest_slot;
    logic               free_seen;
    logic [END_W-1:0]   free_page;
    logic [SLOT_W-1:0]  free_slot;
  } scan_state_t;

  // Running results at reset or scan start
  function automatic scan_state_t cleared_state(logic [PAGE_W-1:0] first_pg,
                                                logic [END_W-1:0]  end_pg);
    scan_state_t s;
    s.oldest_stamp = SENTINEL_STAMP;
    s.oldest_page  = first_pg;
    s.oldest_slot  = '0;
    s.latest_stamp = '0;
    s.latest_page  = first_pg;
    s.latest_slot  = '0;
    s.free_seen    = 1'b0;
    s.free_page    = end_pg;
    s.free_slot    = NONE_SLOT;
    return s;
  endfunction

endpackage

>>> rtl/core/lss_update.sv
// Per-entry compare and update of the running scan results.
// Depends on lss_pkg (entry_t, scan_state_t, cleared_state).
module lss_update (
  input  lss_pkg::entry_t                  ent,
  input  lss_pkg::scan_state_t             cur,
  input  logic [lss_pkg::PAGE_W-1:0]       first_page,
  input  logic [lss_pkg::END_W-1:0]        end_page,
  output lss_pkg::scan_state_t             nxt
);

  lss_pkg::scan_state_t            base;
  logic [lss_pkg::STAMP_W-1:0]     stamp;

  assign stamp = {ent.year, ent.month, ent.day, ent.hour, ent.minute};

  always_comb begin
    base = ent.first ? lss_pkg::cleared_state(first_page, end_page) : cur;
    nxt  = base;
    if (ent.day == '0) begin
      // free slot: only the first one counts
      if (!base.free_seen) begin
        nxt.free_seen = 1'b1;
        nxt.free_page = {1'b0, ent.page};
        nxt.free_slot = ent.slot;
      end
    end else begin
      // strict compares keep the first entry on a tie
      if (stamp < base.oldest_stamp) begin
        nxt.oldest_stamp = stamp;
        nxt.oldest_page  = ent.page;
        nxt.oldest_slot  = ent.slot;
      end
      if (stamp > base.latest_stamp) begin
        nxt.latest_stamp = stamp;
        nxt.latest_page  = ent.page;
        nxt.latest_slot  = ent.slot;
      end
    end
  end

endmodule

>>> rtl/core/log_slot_scanner_top.sv
// Log slot scanner top level: input register, update logic, result register.
// Depends on lss_pkg and lss_update.
// The last entry passes the input register, then its state is loaded into the result register and out_valid rises.
// Throughput: one entry per cycle; the input stalls only while a last entry
//   waits on a full result register that the receiver is stalling.
// Reset (synchronous, rst_n low): first_page 2, end_page 17, results cleared.
module log_slot_scanner_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [lss_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [lss_pkg::CFG_W-1:0]     cfg_wdata,
  // entry stream
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lss_pkg::PAGE_W-1:0]    in_page,
  input  logic [lss_pkg::SLOT_W-1:0]    in_slot,
  input  logic [lss_pkg::DAY_W-1:0]     in_stamp_day,
  input  logic [lss_pkg::MONTH_W-1:0]   in_stamp_month,
  input  logic [lss_pkg::YEAR_W-1:0]    in_stamp_year,
  input  logic [lss_pkg::HOUR_W-1:0]    in_stamp_hour,
  input  logic [lss_pkg::MIN_W-1:0]     in_stamp_minute,
  input  logic                          in_first_entry,
  input  logic                          in_last_entry,
  // scan result
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_free_found,
  output logic [lss_pkg::END_W-1:0]     out_free_page,
  output logic [lss_pkg::SLOT_W-1:0]    out_free_slot,
  output logic [lss_pkg::PAGE_W-1:0]    out_oldest_page,
  output logic [lss_pkg::SLOT_W-1:0]    out_oldest_slot,
  output logic [lss_pkg::PAGE_W-1:0]    out_latest_page,
  output logic [lss_pkg::SLOT_W-1:0]    out_latest_slot
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [lss_pkg::PAGE_W-1:0] first_page_r, first_page_nxt;
  logic [lss_pkg::END_W-1:0]  end_page_r, end_page_nxt;

  always_comb begin
    first_page_nxt = first_page_r;
    end_page_nxt   = end_page_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lss_pkg::CFG_FIRST_PAGE: first_page_nxt = cfg_wdata[lss_pkg::PAGE_W-1:0];
        lss_pkg::CFG_END_PAGE:   end_page_nxt   = cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= lss_pkg::FIRST_PAGE_RST;
      end_page_r   <= lss_pkg::END_PAGE_RST;
    end else begin
      first_page_r <= first_page_nxt;
      end_page_r   <= end_page_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  logic            s1_valid_r, s1_valid_nxt;
  lss_pkg::entry_t s1_ent_r;
  logic            in_xfer;
  logic            s1_adv;    // stage 1 may hand its entry on this cycle
  logic            s1_fire;   // stage 1 entry is folded into the state
  logic            out_load;

  // An entry without the last flag never needs the result register.
  assign s1_adv   = !s1_ent_r.last || !out_valid || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign out_load = s1_fire && s1_ent_r.last;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ent_r.page   <= in_page;
      s1_ent_r.slot   <= in_slot;
      s1_ent_r.day    <= in_stamp_day;
      s1_ent_r.month  <= in_stamp_month;
      s1_ent_r.year   <= in_stamp_year;
      s1_ent_r.hour   <= in_stamp_hour;
      s1_ent_r.minute <= in_stamp_minute;
      s1_ent_r.first  <= in_first_entry;
      s1_ent_r.last   <= in_last_entry;
    end
  end

  // ---------------------------------------------------------------
  // Running results; updated once per fired entry
  // ---------------------------------------------------------------
  lss_pkg::scan_state_t state_r, state_nxt;

  lss_update u_update (
    .ent        (s1_ent_r),
    .cur        (state_r),
    .first_page (first_page_r),
    .end_page   (end_page_r),
    .nxt        (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lss_pkg::cleared_state(lss_pkg::FIRST_PAGE_RST, lss_pkg::END_PAGE_RST);
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Result register: loaded with the state that includes the last entry
  // ---------------------------------------------------------------
  logic                       out_valid_r, out_valid_nxt;
  logic                       free_found_r;
  logic [lss_pkg::END_W-1:0]  free_page_r;
  logic [lss_pkg::SLOT_W-1:0] free_slot_r;
  logic [lss_pkg::PAGE_W-1:0] oldest_page_r;
  logic [lss_pkg::SLOT_W-1:0] oldest_slot_r;
  logic [lss_pkg::PAGE_W-1:0] latest_page_r;
  logic [lss_pkg::SLOT_W-1:0] latest_slot_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      free_found_r  <= state_nxt.free_seen;
      free_page_r   <= state_nxt.free_page;
      free_slot_r   <= state_nxt.free_slot;
      oldest_page_r <= state_nxt.oldest_page;
      oldest_slot_r <= state_nxt.oldest_slot;
      latest_page_r <= state_nxt.latest_page;
      latest_slot_r <= state_nxt.latest_slot;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_free_found  = free_found_r;
  assign out_free_page   = free_page_r;
  assign out_free_slot   = free_slot_r;
  assign out_oldest_page = oldest_page_r;
  assign out_oldest_slot = oldest_slot_r;
  assign out_latest_page = latest_page_r;
  assign out_latest_slot = latest_slot_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // A fired last entry always shows up as a result next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("last entry did not produce a result");

  // Stall only comes from a held last entry facing a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_ent_r.last && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // Free flag is sticky until the next scan start.
  a_free_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.free_seen && !(s1_fire && s1_ent_r.first)) |=> state_r.free_seen)
    else $error("free flag lost within a scan");

  // The first free slot, once found, does not move within a scan.
  a_free_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.free_seen && !(s1_fire && s1_ent_r.first))
      |=> ($stable(state_r.free_page) && $stable(state_r.free_slot)))
    else $error("free position changed within a scan");

endmodule

>>> dv/tb_log_slot_scanner_top.sv
// Self-checking testbench for log_slot_scanner_top: streams entry scans, predicts
// every scan report in place and compares it field by field with what comes out.
// Depends on lss_pkg and the log_slot_scanner_top RTL only; reads no files.
module tb_log_slot_scanner_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lss_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transfer on either side
  localparam int LONG_HOLD      = 300;   // output back-pressure stretch
  localparam int DRAIN_CYCLES   = 6;     // settling wait for entries that produce no report
  localparam int ITEM_TARGET    = 1350;
  localparam int PHASES         = 6;
  localparam int MAX_SHOWN      = 10;

  // Indexes past the register list; the block drops writes to them
  localparam logic [CIDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic [PAGE_W-1:0] REGION_FIRST_AT_RESET = 5'd2;
  localparam logic [END_W-1:0]  REGION_END_AT_RESET   = 6'd17;

  // Oldest search starts at 60-12-31 23:59; only strictly older stamps win
  localparam logic [STAMP_W-1:0] OLDEST_START = {7'd60, 4'd12, 5'd31, 5'd23, 6'd59};
  localparam logic [SLOT_W-1:0]  NO_FREE_SLOT = SLOT_W'(SLOTS_PER_PAGE - 1);

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  typedef struct packed {
    logic              free_found;
    logic [END_W-1:0]  free_page;
    logic [SLOT_W-1:0] free_slot;
    logic [PAGE_W-1:0] oldest_page;
    logic [SLOT_W-1:0] oldest_slot;
    logic [PAGE_W-1:0] latest_page;
    logic [SLOT_W-1:0] latest_slot;
  } scan_report_t;

  // ---------------------------------------------------------------- DUT hookup
  logic              clk;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CIDX_W-1:0] cfg_index = CFG_FIRST_PAGE;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  entry_t            cur_entry = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_free_found;
  logic [END_W-1:0]  out_free_page;
  logic [SLOT_W-1:0] out_free_slot;
  logic [PAGE_W-1:0] out_oldest_page;
  logic [SLOT_W-1:0] out_oldest_slot;
  logic [PAGE_W-1:0] out_latest_page;
  logic [SLOT_W-1:0] out_latest_slot;

  log_slot_scanner_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_page         (cur_entry.page),
    .in_slot         (cur_entry.slot),
    .in_stamp_day    (cur_entry.day),
    .in_stamp_month  (cur_entry.month),
    .in_stamp_year   (cur_entry.year),
    .in_stamp_hour   (cur_entry.hour),
    .in_stamp_minute (cur_entry.minute),
    .in_first_entry  (cur_entry.first),
    .in_last_entry   (cur_entry.last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_free_found  (out_free_found),
    .out_free_page   (out_free_page),
    .out_free_slot   (out_free_slot),
    .out_oldest_page (out_oldest_page),
    .out_oldest_slot (out_oldest_slot),
    .out_latest_page (out_latest_page),
    .out_latest_slot (out_latest_slot)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // A transfer happens at a rising edge with valid high and stall low
  wire in_xfer  = rst_n && in_valid && (in_stall === 1'b0);
  wire out_xfer = rst_n && (out_valid === 1'b1) && !out_stall;

  // ---------------------------------------------------------------- predictor
  // Own copy of the two registers and of the running search state
  logic [PAGE_W-1:0]  region_first;
  logic [END_W-1:0]   region_end;
  logic [STAMP_W-1:0] min_stamp, max_stamp;
  logic [PAGE_W-1:0]  min_page, max_page;
  logic [SLOT_W-1:0]  min_slot, max_slot;
  logic               hole_seen;
  logic [END_W-1:0]   hole_page;
  logic [SLOT_W-1:0]  hole_slot;

  entry_t       entries_pending[$];  // waiting for the driver
  scan_report_t reports_due[$];      // predicted, not yet seen at the output

  int failures      = 0;
  int items_queued  = 0;
  int entries_taken = 0;
  int reports_seen  = 0;
  int cfg_writes    = 0;
  int holds_asked   = 0;
  int holds_served  = 0;
  int quiet_cycles  = 0;

  // Scan start values, taken from the registers as they stand right now
  task automatic restart_search();
    min_stamp = OLDEST_START;
    min_page  = region_first;
    min_slot  = '0;
    max_stamp = '0;
    max_page  = region_first;
    max_slot  = '0;
    hole_seen = 1'b0;
    hole_page = region_end;
    hole_slot = NO_FREE_SLOT;
  endtask

  task automatic absorb_entry(entry_t e);
    logic [STAMP_W-1:0] st;
    st = {e.year, e.month, e.day, e.hour, e.minute};  // raw bits, lexicographic
    if (e.first) restart_search();
    if (e.day == '0) begin
      // free slot: only the first one of the scan counts
      if (!hole_seen) begin
        hole_seen = 1'b1;
        hole_page = END_W'(e.page);
        hole_slot = e.slot;
      end
    end else begin
      // strict compares keep the earlier entry on a tie
      if (st < min_stamp) begin
        min_stamp = st;
        min_page  = e.page;
        min_slot  = e.slot;
      end
      if (st > max_stamp) begin
        max_stamp = st;
        max_page  = e.page;
        max_slot  = e.slot;
      end
    end
    if (e.last)
      reports_due.push_back('{hole_seen, hole_page, hole_slot,
                              min_page, min_slot, max_page, max_slot});
  endtask

  function automatic string format_report(scan_report_t r);
    return $sformatf("free=%0d at %0d.%0d oldest=%0d.%0d latest=%0d.%0d",
                     r.free_found, r.free_page, r.free_slot,
                     r.oldest_page, r.oldest_slot, r.latest_page, r.latest_slot);
  endfunction

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------- monitor
  logic in_taken = 1'b0;  // last rising edge moved the offered entry

  always @(posedge clk) begin : watch_transfers
    scan_report_t got;
    scan_report_t want;
    in_taken <= in_xfer;
    if (in_xfer) begin
      absorb_entry(cur_entry);
      entries_taken++;
    end
    if (out_xfer) begin
      got = '{out_free_found, out_free_page, out_free_slot, out_oldest_page,
              out_oldest_slot, out_latest_page, out_latest_slot};
      reports_seen++;
      if (reports_due.size() == 0) begin
        note_failure({"report with nothing pending: ", format_report(got)});
      end else begin
        want = reports_due.pop_front();
        if (got !== want)
          note_failure({"expected ", format_report(want), " got ", format_report(got)});
      end
    end
  end

  // Ends the run when neither side has moved for too long
  always @(posedge clk) begin : watchdog
    if (in_xfer || out_xfer) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d reports outstanding",
               WATCHDOG_LIMIT, reports_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver
  // Bursts of random length, random gaps between them; payload held while stalled
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin : drive_entries
    logic   next_valid;
    entry_t next_entry;
    next_valid = in_valid && !in_taken;
    next_entry = cur_entry;
    if (!next_valid && rst_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (entries_pending.size() != 0) begin
        next_entry = entries_pending.pop_front();
        next_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_valid  <= next_valid;
    cur_entry <= next_entry;
  end

  // ---------------------------------------------------------------- receiver
  // Stall pattern switches among random modes; a long hold on request
  int          hold_left  = 0;
  int          mode_left  = 0;
  stall_mode_e stall_mode = STALL_NONE;

  always @(negedge clk) begin : drive_out_stall
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= (mode_left % 3 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic entry_t make_entry(int pg, int sl, int d, int mo, int yr, int hr,
                                        int mi, bit f, bit l);
    entry_t e;
    e.page   = PAGE_W'(pg);
    e.slot   = SLOT_W'(sl);
    e.day    = DAY_W'(d);
    e.month  = MONTH_W'(mo);
    e.year   = YEAR_W'(yr);
    e.hour   = HOUR_W'(hr);
    e.minute = MIN_W'(mi);
    e.first  = f;
    e.last   = l;
    return e;
  endfunction

  task automatic offer(entry_t e);
    entries_pending.push_back(e);
    items_queued++;
  endtask

  // Fills the stamp: free slots, ties with the previous entry, stamps clustered
  // near the sentinel, raw out-of-range values, or ordinary calendar values
  function automatic entry_t stamp_entry(entry_t e, entry_t prev, int hole_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < hole_pct) begin
      e.day = '0;
      {e.month, e.year, e.hour, e.minute} = 22'($urandom);  // junk, ignored
      return e;
    end
    pick = $urandom_range(0, 99);
    if (pick < 12 && prev.day != '0) begin
      {e.day, e.month, e.year, e.hour, e.minute} =
        {prev.day, prev.month, prev.year, prev.hour, prev.minute};
    end else if (pick < 30) begin
      e.year   = YEAR_W'($urandom_range(59, 61));
      e.month  = ($urandom_range(0, 1) == 0) ? MONTH_W'(12) : MONTH_W'($urandom);
      e.day    = DAY_W'($urandom_range(30, 31));
      e.hour   = HOUR_W'($urandom_range(22, 23));
      e.minute = MIN_W'($urandom_range(56, 63));
    end else if (pick < 42) begin
      {e.month, e.year, e.hour, e.minute} = 22'($urandom);
      e.day = DAY_W'($urandom_range(1, 31));
    end else begin
      e.day    = DAY_W'($urandom_range(1, 31));
      e.month  = MONTH_W'($urandom_range(0, 12));
      e.year   = YEAR_W'($urandom_range(0, 99));
      e.hour   = HOUR_W'($urandom_range(0, 23));
      e.minute = MIN_W'($urandom_range(0, 59));
    end
    return e;
  endfunction

  // One scan: positions in page/slot order unless scrambled
  task automatic queue_scan(int len, int hole_pct, bit with_start, bit in_order);
    entry_t e;
    entry_t prev;
    int     pg;
    int     sl;
    pg   = $urandom_range(0, 31);
    sl   = $urandom_range(0, SLOTS_PER_PAGE - 1);
    prev = '0;
    for (int i = 0; i < len; i++) begin
      e = '0;
      if (in_order) begin
        e.page = PAGE_W'(pg);
        e.slot = SLOT_W'(sl);
        sl++;
        if (sl == SLOTS_PER_PAGE) begin
          sl = 0;
          pg++;
        end
      end else begin
        e.page = PAGE_W'($urandom);
        e.slot = SLOT_W'($urandom);
      end
      e       = stamp_entry(e, prev, hole_pct);
      e.first = with_start && (i == 0);
      e.last  = (i == len - 1);
      offer(e);
      prev = e;
    end
  endtask

  // Mostly well-formed scans; some without a scan start, some scrambled, some strays
  task automatic random_phase(int budget);
    entry_t e;
    int     start_cnt;
    int     pick;
    int     len;
    int     hole_pct;
    start_cnt = items_queued;
    while (items_queued - start_cnt < budget) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      case ($urandom_range(0, 4))
        0:       hole_pct = 0;
        1:       hole_pct = 10;
        2:       hole_pct = 25;
        3:       hole_pct = 60;
        default: hole_pct = 100;
      endcase
      if (pick < 80) begin
        queue_scan(len, hole_pct, 1'b1, 1'b1);
      end else if (pick < 88) begin
        queue_scan(len, hole_pct, 1'b0, 1'b1);  // accumulates from the last clear
      end else if (pick < 94) begin
        queue_scan(len, hole_pct, 1'b1, 1'b0);
      end else begin
        e       = '0;
        e.page  = PAGE_W'($urandom);
        e.slot  = SLOT_W'($urandom);
        e       = stamp_entry(e, '0, 30);
        e.first = 1'($urandom);
        e.last  = 1'($urandom);
        offer(e);
      end
    end
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      CFG_FIRST_PAGE: region_first = data[PAGE_W-1:0];
      CFG_END_PAGE:   region_end   = data;
      default:        ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Sender holds off until the input side is empty and every report is back,
  // then a settling wait for entries that produce nothing
  task automatic wait_drained();
    do @(posedge clk); while (entries_pending.size() != 0 || in_valid);
    while (reports_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    region_first = REGION_FIRST_AT_RESET;
    region_end   = REGION_END_AT_RESET;
    restart_search();
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed scans at the reset register values
    offer(make_entry(3, 1, 15, 6, 24, 10, 30, 1, 1));   // lone used entry
    offer(make_entry(9, 2, 0, 6, 24, 10, 30, 1, 1));    // lone free slot: defaults
    offer(make_entry(4, 0, 5, 5, 50, 5, 5, 1, 0));      // tie below keeps this one
    offer(make_entry(4, 1, 0, 0, 0, 0, 0, 0, 0));       // first free slot
    offer(make_entry(4, 2, 5, 5, 50, 5, 5, 0, 0));
    offer(make_entry(4, 3, 0, 9, 9, 9, 9, 0, 0));       // later free slot, ignored
    offer(make_entry(5, 0, 5, 5, 50, 5, 6, 0, 0));      // newer by a minute
    offer(make_entry(5, 1, 5, 5, 50, 5, 4, 0, 1));      // older by a minute
    offer(make_entry(7, 0, 31, 12, 60, 23, 59, 1, 1));  // sentinel stamp, never oldest
    offer(make_entry(7, 1, 31, 12, 60, 23, 59, 1, 0));
    offer(make_entry(7, 2, 31, 12, 60, 23, 58, 0, 1));  // just under the sentinel
    offer(make_entry(31, 3, 31, 15, 127, 31, 63, 1, 0)); // all-ones raw stamp
    offer(make_entry(0, 0, 1, 0, 0, 0, 0, 0, 1));       // smallest used stamp
    offer(make_entry(12, 2, 1, 0, 0, 0, 0, 0, 0));      // no scan start, ties the min
    offer(make_entry(12, 3, 0, 15, 127, 31, 63, 0, 1)); // free slot with junk stamp
    offer(make_entry(0, 0, 0, 0, 0, 0, 0, 1, 1));       // all-zero fields
    offer(make_entry(20, 1, 31, 12, 99, 23, 59, 1, 0)); // calendar maximum
    offer(make_entry(20, 2, 1, 1, 0, 0, 0, 0, 1));      // calendar minimum
    random_phase(ITEM_TARGET / PHASES);
    wait_drained();

    // Later phases: each starts from a new register setting while idle
    for (int ph = 1; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_FIRST_PAGE, 6'd0);
          write_reg(CFG_END_PAGE, 6'd0);
        end
        2: begin
          write_reg(CFG_FIRST_PAGE, 6'h3F);  // upper bit dropped
          write_reg(CFG_END_PAGE, 6'd63);
          // Long output hold while one-entry scans keep coming: fills the block
          holds_asked++;
          repeat (40) queue_scan(1, 20, 1'b1, 1'b1);
        end
        3: begin
          write_reg(CFG_SPARE_2, CFG_W'($urandom));
          write_reg(CFG_SPARE_3, CFG_W'($urandom));
          write_reg(CFG_END_PAGE, 6'd32);
          write_reg(CFG_FIRST_PAGE, CFG_W'($urandom));
        end
        4: begin
          write_reg(CFG_FIRST_PAGE, CFG_W'($urandom));
          write_reg(CFG_END_PAGE, CFG_W'($urandom));
        end
        default: begin
          write_reg(CFG_FIRST_PAGE, 6'd37);
          write_reg(CFG_END_PAGE, 6'd17);
        end
      endcase
      random_phase(ITEM_TARGET / PHASES);
      wait_drained();
    end

    if (reports_due.size() != 0)
      note_failure($sformatf("%0d reports never arrived", reports_due.size()));
    $display("Run covered %0d entries, %0d scan reports, %0d register writes, %0d long holds",
             entries_taken, reports_seen, cfg_writes, holds_served);
    $display("Mismatches counted: %0d", failures);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
